// ===== rtl/core/ladf_pkg.sv =====
// shared types, codes and the microcode table of the ladder filter
package ladf_pkg;

  typedef logic signed [23:0] ladf_q_t;
  typedef logic [3:0]         ladf_step_t;

  // micro-operations
  localparam logic [2:0] OP_WAIT = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_ACC  = 3'd2;
  localparam logic [2:0] OP_ADD  = 3'd3;
  localparam logic [2:0] OP_OUT  = 3'd4;

  // multiplier operand sets
  localparam logic [1:0] SRC_IN   = 2'd0;
  localparam logic [1:0] SRC_POLE = 2'd1;
  localparam logic [1:0] SRC_CLIP = 2'd2;
  localparam logic [1:0] SRC_LOOP = 2'd3;

  // accumulate destinations
  localparam logic [1:0] DST_X     = 2'd0;
  localparam logic [1:0] DST_XPOLE = 2'd1;
  localparam logic [1:0] DST_LOOP  = 2'd2;
  localparam logic [1:0] DST_NONE  = 2'd3;

  // sequencer jumps
  localparam logic [1:0] JMP_NONE   = 2'd0;
  localparam logic [1:0] JMP_MORE   = 2'd1;
  localparam logic [1:0] JMP_ALWAYS = 2'd2;

  // program steps
  localparam ladf_step_t STEP_WAIT     = 4'd0;
  localparam ladf_step_t STEP_IN_MUL   = 4'd1;
  localparam ladf_step_t STEP_IN_ACC   = 4'd2;
  localparam ladf_step_t STEP_POLE     = 4'd3;
  localparam ladf_step_t STEP_POLE_ACC = 4'd4;
  localparam ladf_step_t STEP_CLIPA    = 4'd5;
  localparam ladf_step_t STEP_CLIPA_AC = 4'd6;
  localparam ladf_step_t STEP_SUM      = 4'd7;
  localparam ladf_step_t STEP_CLIPB    = 4'd8;
  localparam ladf_step_t STEP_CLIPB_AC = 4'd9;
  localparam ladf_step_t STEP_LOOP     = 4'd10;
  localparam ladf_step_t STEP_LOOP_ACC = 4'd11;
  localparam ladf_step_t STEP_OUT      = 4'd12;

  // register map
  localparam logic [2:0] REG_POLE_COEFF    = 3'd0;
  localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [2:0] REG_CLIP_BLEND    = 3'd2;
  localparam logic [2:0] REG_CLIP_LIMIT    = 3'd3;
  localparam logic [2:0] REG_PASS_MODE     = 3'd4;

  localparam logic [1:0] MODE_LP = 2'd0;
  localparam logic [1:0] MODE_HP = 2'd1;
  localparam logic [1:0] MODE_BP = 2'd2;

  localparam logic [15:0] CLIP_BLEND_RST = 16'd32768;
  localparam logic [21:0] CLIP_LIMIT_RST = 22'd1048576;

  // 2^13 with a shift of 15 gives the divide by four
  localparam logic signed [16:0] IN_QUARTER = 17'sd8192;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] src;
    logic [1:0] dst;
    logic       sh14;
    logic [1:0] jmp;
    ladf_step_t target;
  } ladf_cw_t;

  typedef struct packed {
    ladf_cw_t cw;
    logic     go;
  } ladf_ctl_t;

  function automatic ladf_cw_t ladf_ucode(input ladf_step_t step);
    ladf_cw_t w;
    w = '{op: OP_WAIT, src: SRC_IN, dst: DST_NONE, sh14: 1'b0, jmp: JMP_NONE,
          target: STEP_WAIT};
    case (step)
      STEP_WAIT:     w.op = OP_WAIT;
      STEP_IN_MUL:   begin w.op = OP_MUL; w.src = SRC_IN; end
      STEP_IN_ACC:   begin w.op = OP_ACC; w.dst = DST_X; end
      STEP_POLE:     begin w.op = OP_MUL; w.src = SRC_POLE; end
      STEP_POLE_ACC: begin w.op = OP_ACC; w.dst = DST_X; end
      STEP_CLIPA:    begin w.op = OP_MUL; w.src = SRC_CLIP; end
      STEP_CLIPA_AC: begin w.op = OP_ACC; w.dst = DST_XPOLE; end
      STEP_SUM:      w.op = OP_ADD;
      STEP_CLIPB:    begin w.op = OP_MUL; w.src = SRC_CLIP; end
      STEP_CLIPB_AC: begin
        w.op = OP_ACC; w.dst = DST_X; w.jmp = JMP_MORE; w.target = STEP_POLE;
      end
      STEP_LOOP:     begin w.op = OP_MUL; w.src = SRC_LOOP; end
      STEP_LOOP_ACC: begin w.op = OP_ACC; w.dst = DST_LOOP; w.sh14 = 1'b1; end
      STEP_OUT:      begin w.op = OP_OUT; w.jmp = JMP_ALWAYS; w.target = STEP_WAIT; end
      default: begin
        w.op = OP_OUT; w.jmp = JMP_ALWAYS; w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/ladf_in_if.sv =====
// sample input channel
interface ladf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

// ===== rtl/core/ladf_out_if.sv =====
// filtered sample output channel
interface ladf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;
  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

// ===== rtl/core/ladf_seq.sv =====
// microcode sequencer: step counter, pole counter and program table
module ladf_seq #(
  parameter int POLES = 4,
  parameter int KW    = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_block,
  output logic                in_ready,
  output ladf_pkg::ladf_ctl_t ctl,
  output logic [KW-1:0]       k_r
);
  import ladf_pkg::*;

  ladf_step_t    step_r, step_nxt;
  logic [KW-1:0] k_nxt;
  ladf_cw_t      cw;
  logic          stall;
  logic          more;

  assign cw       = ladf_ucode(step_r);
  assign stall    = ((cw.op == OP_WAIT) && !in_valid) || ((cw.op == OP_OUT) && out_block);
  assign more     = (k_r != KW'(POLES - 1));
  assign in_ready = (cw.op == OP_WAIT);
  assign ctl      = '{cw: cw, go: !stall};

  always_comb begin
    step_nxt = step_r;
    k_nxt    = k_r;
    if (!stall) begin
      case (cw.jmp)
        JMP_ALWAYS: step_nxt = cw.target;
        JMP_MORE: begin
          if (more) begin
            step_nxt = cw.target;
            k_nxt    = k_r + KW'(1);
          end else begin
            step_nxt = step_r + 4'd1;
            k_nxt    = '0;
          end
        end
        default: step_nxt = step_r + 4'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
      k_r    <= '0;
    end else begin
      step_r <= step_nxt;
      k_r    <= k_nxt;
    end
  end

endmodule

// ===== rtl/core/ladf_datapath.sv =====
// shared multiply, round and saturate datapath with pole and loop state
module ladf_datapath #(
  parameter int POLES = 4,
  parameter int KW    = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ladf_pkg::ladf_ctl_t ctl,
  input  logic [KW-1:0]       k,
  input  logic signed [15:0]  in_sample,
  input  logic signed [15:0]  pole_coeff,
  input  logic [15:0]         feedback_gain,
  input  logic [15:0]         clip_blend,
  input  logic [21:0]         clip_limit,
  input  logic [1:0]          pass_mode,
  output logic signed [15:0]  out_sample
);
  import ladf_pkg::*;

  localparam int BP = (POLES >= 3) ? 2 : POLES - 1;

  function automatic ladf_q_t sat24(input logic signed [28:0] v);
    ladf_q_t r;
    if (v > 29'sd8388607)       r = 24'sh7FFFFF;
    else if (v < -29'sd8388608) r = 24'sh800000;
    else                        r = v[23:0];
    return r;
  endfunction

  ladf_q_t            pole_r [POLES];
  ladf_q_t            loop_r;
  ladf_q_t            x_r, t_r, base_r;
  logic signed [15:0] in_r;
  logic signed [41:0] prod_r;
  logic signed [15:0] out_r;

  logic signed [24:0] inq, x25, pk25, lim, c25, a_op;
  logic signed [16:0] b_op;
  ladf_q_t            base_op;
  logic signed [41:0] mul_p;
  logic signed [42:0] prod_x, rnd;
  logic signed [28:0] shifted, acc_sum;
  ladf_q_t            acc_res, add_res;
  logic signed [26:0] x27, inq27, pbp27, r27;
  logic signed [26:0] rr;
  logic signed [15:0] out_nxt;

  assign inq  = {{4{in_r[15]}}, in_r, 5'b0};
  assign x25  = {x_r[23], x_r};
  assign pk25 = {pole_r[k][23], pole_r[k]};
  assign lim  = {3'b000, clip_limit};

  // hard clamp at the limit, blended in through the multiplier
  always_comb begin
    if (x25 > lim)       c25 = lim;
    else if (x25 < -lim) c25 = -lim;
    else                 c25 = x25;
  end

  always_comb begin
    case (ctl.cw.src)
      SRC_IN: begin
        a_op = inq - {loop_r[23], loop_r}; b_op = IN_QUARTER; base_op = '0;
      end
      SRC_POLE: begin
        a_op = x25 - pk25; b_op = {pole_coeff[15], pole_coeff}; base_op = x_r;
      end
      SRC_CLIP: begin
        a_op = c25 - x25; b_op = {1'b0, clip_blend}; base_op = x_r;
      end
      default: begin
        a_op = x25; b_op = {1'b0, feedback_gain}; base_op = '0;
      end
    endcase
  end

  assign mul_p = a_op * b_op;

  // round half up then add the base and saturate
  assign prod_x  = {prod_r[41], prod_r};
  assign rnd     = ctl.cw.sh14 ? (prod_x + 43'sd8192) : (prod_x + 43'sd16384);
  assign shifted = ctl.cw.sh14 ? 29'(rnd >>> 14) : 29'(rnd >>> 15);
  assign acc_sum = {{5{base_r[23]}}, base_r} + shifted;
  assign acc_res = sat24(acc_sum);
  assign add_res = sat24({{5{x_r[23]}}, x_r} + {{5{t_r[23]}}, t_r});

  // output selection
  assign x27   = {{3{x_r[23]}}, x_r};
  assign inq27 = {{2{inq[24]}}, inq};
  assign pbp27 = {{3{pole_r[BP][23]}}, pole_r[BP]};
  always_comb begin
    case (pass_mode)
      MODE_HP: r27 = inq27 - x27;
      MODE_BP: r27 = pbp27 + (pbp27 <<< 1) - x27;
      default: r27 = x27;
    endcase
    rr = (r27 + 27'sd16) >>> 5;
    if (rr > 27'sd32767)       out_nxt = 16'sh7FFF;
    else if (rr < -27'sd32768) out_nxt = 16'sh8000;
    else                       out_nxt = rr[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r <= '0;
      for (int i = 0; i < POLES; i++) pole_r[i] <= '0;
    end else if (ctl.cw.op == OP_ACC) begin
      if (ctl.cw.dst == DST_XPOLE) pole_r[k] <= acc_res;
      if (ctl.cw.dst == DST_LOOP)  loop_r    <= acc_res;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cw.op)
      OP_WAIT: if (ctl.go) in_r <= in_sample;
      OP_MUL: begin
        prod_r <= mul_p;
        base_r <= base_op;
        if (ctl.cw.src == SRC_POLE) t_r <= pole_r[k];
      end
      OP_ACC: if (ctl.cw.dst == DST_X || ctl.cw.dst == DST_XPOLE) x_r <= acc_res;
      OP_ADD: x_r <= add_res;
      OP_OUT: if (ctl.go) out_r <= out_nxt;
      default: ;
    endcase
  end

  assign out_sample = out_r;

endmodule

// ===== rtl/core/saturating_four_pole_ladder_filter.sv =====
// Saturating ladder filter with a cascade of POLES one-pole sections and
// resonance feedback. Each item is one signed Q1.15 sample in and one
// filtered Q1.15 sample out. Every product goes through one shared 25x17
// multiplier, a multiply step then a round-and-saturate step, stepped by a
// 13-word microcode program. A new item is taken at the edge after the
// previous one is loaded into the output register, so the block never works
// on two items at once; the sequencer holds on its last step only while
// that register still carries an untaken result. Configuration is over the
// APB port at byte address 4*index and must only be written while the
// block is idle.
module saturating_four_pole_ladder_filter #(
  parameter int POLES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ladf_in_if.sink     in_ch,
  ladf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ladf_pkg::*;

  localparam int KW = (POLES > 1) ? $clog2(POLES) : 1;

  logic signed [15:0] pole_coeff_r;
  logic [15:0]        feedback_gain_r;
  logic [15:0]        clip_blend_r;
  logic [21:0]        clip_limit_r;
  logic [1:0]         pass_mode_r;
  logic               out_valid_r, out_valid_nxt;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  ladf_ctl_t          ctl;
  logic [KW-1:0]      k_r;
  logic               out_block;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_coeff_r    <= '0;
      feedback_gain_r <= '0;
      clip_blend_r    <= CLIP_BLEND_RST;
      clip_limit_r    <= CLIP_LIMIT_RST;
      pass_mode_r     <= MODE_LP;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POLE_COEFF:    pole_coeff_r    <= pwdata[15:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= pwdata[15:0];
        REG_CLIP_BLEND:    clip_blend_r    <= pwdata[15:0];
        REG_CLIP_LIMIT:    clip_limit_r    <= pwdata[21:0];
        REG_PASS_MODE:     pass_mode_r     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POLE_COEFF:    prdata = {16'b0, pole_coeff_r};
      REG_FEEDBACK_GAIN: prdata = {16'b0, feedback_gain_r};
      REG_CLIP_BLEND:    prdata = {16'b0, clip_blend_r};
      REG_CLIP_LIMIT:    prdata = {10'b0, clip_limit_r};
      REG_PASS_MODE:     prdata = {30'b0, pass_mode_r};
      default:           prdata = '0;
    endcase
  end

  assign out_block = out_valid_r && !out_ch.ready;

  ladf_seq #(.POLES(POLES), .KW(KW)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_block (out_block),
    .in_ready  (in_ch.ready),
    .ctl       (ctl),
    .k_r       (k_r)
  );

  ladf_datapath #(.POLES(POLES), .KW(KW)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .k             (k_r),
    .in_sample     (in_ch.in_sample),
    .pole_coeff    (pole_coeff_r),
    .feedback_gain (feedback_gain_r),
    .clip_blend    (clip_blend_r),
    .clip_limit    (clip_limit_r),
    .pass_mode     (pass_mode_r),
    .out_sample    (out_ch.out_sample)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (ctl.go && ctl.cw.op == OP_OUT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  assign out_ch.valid = out_valid_r;

  // sequencer leaves the wait step straight after taking an item
  a_leave_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted but sequencer stayed in wait");

  // a result only appears from the output step
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.go && ctl.cw.op == OP_OUT))
    else $error("output valid without an output step");

  // a pending result holds the sequencer on the output step
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cw.op == OP_OUT && out_valid_r && !out_ch.ready)
      |=> (ctl.cw.op == OP_OUT && out_valid_r))
    else $error("output step left while result pending");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(k_r) < POLES)
    else $error("pole counter out of range");

endmodule

// ===== sim/ladf_filter_checker.sv =====
// ladder filter checker: snoops the register port and both channels, predicts and compares
`timescale 1ns / 1ps

module ladf_filter_checker #(
  parameter int POLES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fails,
  output int                 pending,
  output int                 n_checked
);
  import ladf_pkg::*;

  localparam longint Q_MAX = 64'sd8388607;
  localparam longint Q_MIN = -64'sd8388608;
  // bandpass taps the third pole, or the last one on a short cascade
  localparam int BP_TAP = (POLES >= 3) ? 2 : POLES - 1;

  // shadow of the filter registers
  logic signed [15:0] pole_p;
  logic [15:0]        fb_gain;
  logic [15:0]        blend_q15;
  logic [21:0]        limit_q20;
  logic [1:0]         pass_sel;

  // shadow of the filter state
  ladf_q_t pole_q [POLES];
  ladf_q_t loop_q;

  logic signed [15:0] filtered_q [$];

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // blend of a hard clamp at the limit with the raw value
  function automatic longint soft_clip(longint v);
    longint c;
    longint lim;
    longint a;
    lim = longint'({42'd0, limit_q20});
    a = longint'({48'd0, blend_q15});
    c = v;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    return sat_q(rnd_shift(a * c + (64'sd32768 - a) * v, 15));
  endfunction

  function automatic logic signed [15:0] filter_step(logic signed [15:0] smp);
    longint inq;
    longint x;
    longint t;
    longint s;
    longint r;
    int k;
    inq = longint'(smp) * 32;
    x = sat_q(rnd_shift(inq - longint'(loop_q), 2));
    for (k = 0; k < POLES; k++) begin
      t = longint'(pole_q[k]);
      s = sat_q(x + rnd_shift((x - t) * longint'(pole_p), 15));
      x = soft_clip(s);
      pole_q[k] = ladf_q_t'(x);
      x = soft_clip(sat_q(x + t));
    end
    case (pass_sel)
      MODE_HP: r = inq - x;
      MODE_BP: r = 3 * longint'(pole_q[BP_TAP]) - x;
      default: r = x;
    endcase
    r = rnd_shift(r, 5);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    loop_q = ladf_q_t'(sat_q(rnd_shift(x * longint'({48'd0, fb_gain}), 14)));
    return r[15:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pole_p    <= '0;
      fb_gain   <= '0;
      blend_q15 <= CLIP_BLEND_RST;
      limit_q20 <= CLIP_LIMIT_RST;
      pass_sel  <= MODE_LP;
      for (int k = 0; k < POLES; k++) pole_q[k] = '0;
      loop_q    = '0;
      filtered_q.delete();
      fails     <= 0;
      pending   <= 0;
      n_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_POLE_COEFF:    pole_p    <= pwdata[15:0];
          REG_FEEDBACK_GAIN: fb_gain   <= pwdata[15:0];
          REG_CLIP_BLEND:    blend_q15 <= pwdata[15:0];
          REG_CLIP_LIMIT:    limit_q20 <= pwdata[21:0];
          REG_PASS_MODE:     pass_sel  <= pwdata[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("out_sample: no item pending, got %0d", out_sample);
          fails <= fails + 1;
        end else begin
          logic signed [15:0] want;
          want = filtered_q.pop_front();
          if (want !== out_sample) begin
            $error("out_sample: expected %0d, got %0d", want, out_sample);
            fails <= fails + 1;
          end
          n_checked <= n_checked + 1;
        end
      end
      // blocking update of the shadow state; registers must only move while idle, the filter does not enforce it
      if (in_valid && in_ready)
        filtered_q.push_back(filter_step(in_sample));
      pending <= filtered_q.size();
    end
  end

endmodule

// ===== sim/tb_saturating_four_pole_ladder_filter.sv =====
// testbench top: clock, reset, register writes, sample stimulus and verdict
`timescale 1ns / 1ps

module tb_saturating_four_pole_ladder_filter;
  import ladf_pkg::*;

  localparam int POLES = 4;
  // indexes past the register map, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  // the one mode code with no filter of its own
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [15:0] coeff;
    logic [15:0] gain;
    logic [15:0] blend;
    logic [21:0] limit;
    logic [1:0]  mode;
  } filt_cfg_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int pending;
  int n_checked;
  int tx_idle_pct;
  int rx_idle_pct;
  int n_items;
  int n_settings;

  ladf_in_if  in_ch ();
  ladf_out_if out_ch ();

  saturating_four_pole_ladder_filter #(.POLES(POLES)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ladf_filter_checker #(.POLES(POLES)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.in_sample),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.out_sample),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fails      (fails),
    .pending    (pending),
    .n_checked  (n_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #8ms;
    $display("saturating_four_pole_ladder_filter regression: fail");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_settings(input filt_cfg_t c);
    reg_write(REG_POLE_COEFF, {16'd0, c.coeff});
    reg_write(REG_FEEDBACK_GAIN, {16'd0, c.gain});
    reg_write(REG_CLIP_BLEND, {16'd0, c.blend});
    reg_write(REG_CLIP_LIMIT, {10'd0, c.limit});
    reg_write(REG_PASS_MODE, {30'd0, c.mode});
    n_settings++;
  endtask

  task automatic push_sample(input logic signed [15:0] smp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_items++;
  endtask

  // lower valid and wait for every filtered item to come back
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_burst(input logic signed [15:0] burst[$]);
    foreach (burst[i]) push_sample(burst[i]);
    drain();
  endtask

  function automatic filt_cfg_t pick_settings();
    filt_cfg_t c;
    case ($urandom_range(5))
      0: c.coeff = 16'h8000;
      1: c.coeff = 16'h7fff;
      default: c.coeff = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0: c.gain = 16'd0;
      1: c.gain = 16'hffff;
      default: c.gain = 16'($urandom);
    endcase
    case ($urandom_range(5))
      0: c.blend = 16'd6554;
      1: c.blend = CLIP_BLEND_RST;
      2: c.blend = 16'($urandom);
      default: c.blend = 16'($urandom_range(6554, 32768));
    endcase
    case ($urandom_range(5))
      0: c.limit = 22'd0;
      1: c.limit = 22'h3fffff;
      default: c.limit = 22'($urandom_range(0, 4194303));
    endcase
    c.mode = 2'($urandom_range(3));
    return c;
  endfunction

  // mix of full-scale noise, held levels, quiet passages, sign flips and rail hits
  function automatic logic signed [15:0] next_sample(input logic signed [15:0] prev);
    case ($urandom_range(9))
      4, 5: return prev;
      6, 7: return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      8: return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
      9: return -prev;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] smp;
    int phase;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_sample = '0;
    tx_idle_pct = 18;
    rx_idle_pct = 64;
    n_items = 0;
    n_settings = 0;
    smp = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, with writes past the register map that must be ignored
    reg_write(REG_SPARE_LO, 32'hffff_ffff);
    reg_write(REG_SPARE_HI, 32'hffff_ffff);
    push_burst('{16'sd0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd1, -16'sd1, 16'sd0});

    // highpass, widest cutoff, full feedback, widest limit
    load_settings('{coeff: 16'h7fff, gain: 16'hffff, blend: CLIP_BLEND_RST,
                    limit: 22'h3fffff, mode: MODE_HP});
    push_burst('{16'sh7fff, 16'sh8000, 16'sd12345, -16'sd1});

    // bandpass, negative coefficient, blend above one, zero limit
    load_settings('{coeff: 16'h8000, gain: 16'd0, blend: 16'hffff,
                    limit: 22'd0, mode: MODE_BP});
    push_burst('{16'sh7fff, 16'sh8000, 16'sh5555, -16'sd21846});

    // unused mode falls back to lowpass, light blend
    load_settings('{coeff: 16'd16384, gain: 16'd60000, blend: 16'd6554,
                    limit: CLIP_LIMIT_RST, mode: MODE_SPARE});
    push_burst('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0});

    // zero blend leaves the raw value, bandpass with unity feedback
    load_settings('{coeff: 16'd0, gain: 16'd16384, blend: 16'd0,
                    limit: 22'h3fffff, mode: MODE_BP});
    push_burst('{16'sh8000, 16'sh7fff, 16'sd1000, -16'sd1000});

    for (phase = 0; phase < 16; phase++) begin
      if (phase < 6) begin
        tx_idle_pct = 18;
        rx_idle_pct = 64;
      end else if (phase < 11) begin
        tx_idle_pct = 64;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      load_settings(pick_settings());
      repeat (100) begin
        smp = next_sample(smp);
        push_sample(smp);
      end
      drain();
    end

    repeat (40) @(negedge clk);
    $display("%0d samples driven through %0d filter settings, %0d results compared",
             n_items, n_settings, n_checked);
    $display("modes, clip limit and blend extremes, rail inputs and unmapped writes included");
    if (fails == 0 && pending == 0) begin
      $display("saturating_four_pole_ladder_filter regression: pass");
    end else begin
      $display("saturating_four_pole_ladder_filter regression: fail");
    end
    $finish;
  end

endmodule
